### sv/adf_pkg.sv
// Shared types and constants of the accessory display deframer.
package adf_pkg;

	// Message classes decided from the header id and kind.
	typedef enum logic [1:0] {
		MK_CONTENT = 2'd0,
		MK_QUERY   = 2'd1,
		MK_UNKNOWN = 2'd2
	} adf_msg_kind_t;

	// Header field values that select a message class.
	localparam logic [15:0] HDR_ID_ACCESSORY = 16'd1;
	localparam logic [15:0] HDR_KIND_QUERY   = 16'd2 - 16'd1;
	localparam logic [15:0] HDR_KIND_CONTENT = 16'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd0;
	localparam logic [1:0] CFG_REPLY_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_REPLY_HEIGHT  = 2'd2;
	localparam logic [1:0] CFG_REPLY_DPI     = 2'd3;

	// Configuration reset values.
	localparam logic [31:0] RST_PAYLOAD_LIMIT = 32'd2097152;
	localparam logic [31:0] RST_REPLY_WIDTH   = 32'd720;
	localparam logic [31:0] RST_REPLY_HEIGHT  = 32'd1280;
	localparam logic [31:0] RST_REPLY_DPI     = 32'd96;

	// Reply: fixed 8-byte preamble, then width, height and dpi words.
	localparam logic [63:0] REPLY_PREAMBLE = 64'h0002_0001_0000_000C;
	localparam logic [4:0]  REPLY_LAST     = 5'd19;
	localparam logic [2:0]  WORD_WIDTH     = 3'd2;
	localparam logic [2:0]  WORD_HEIGHT    = 3'd3;

	// Output kind codes.
	localparam logic OUT_STREAM = 1'b0;
	localparam logic OUT_REPLY  = 1'b1;

	// Query capture is complete after this many payload bytes.
	localparam logic [3:0] CAPTURE_BYTES = 4'd8;

	// Command handed from the parser to the emitter.
	typedef struct packed {
		logic        reply;
		logic [7:0]  data;
		logic [30:0] width;
		logic [30:0] height;
	} adf_cmd_t;

	// Reply words taken from the configuration registers.
	typedef struct packed {
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] dpi;
	} adf_reply_t;

endpackage

### sv/adf_front.sv
// Header parser and message classifier: turns received beats into commands.
module adf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        rx_byte,
	input  logic              end_of_transfer,
	input  logic [31:0]       payload_limit,
	output logic              push,
	output adf_pkg::adf_cmd_t cmd
);
	import adf_pkg::*;

	typedef enum logic [2:0] {
		ST_HEADER  = 3'b001,
		ST_PAYLOAD = 3'b010,
		ST_DROP    = 3'b100
	} adf_state_t;

	adf_state_t    state_q, state_d;
	logic [55:0]   hdr_q, hdr_d;
	logic [2:0]    hdr_cnt_q, hdr_cnt_d;
	logic [31:0]   remain_q, remain_d;
	adf_msg_kind_t kind_q, kind_d;
	logic [63:0]   cap_q, cap_d;
	logic [3:0]    cap_cnt_q, cap_cnt_d;
	logic [30:0]   width_q, width_d;
	logic [30:0]   height_q, height_d;

	logic [63:0] hdr_full;
	logic [15:0] hdr_id;
	logic [15:0] hdr_kind;
	logic [31:0] hdr_len;
	logic        finish;
	logic [31:0] cap_w;
	logic [31:0] cap_h;
	logic        size_ok;

	assign hdr_full = {hdr_q, rx_byte};
	assign hdr_id   = hdr_full[63:48];
	assign hdr_kind = hdr_full[47:32];
	assign hdr_len  = hdr_full[31:0];

	always_comb begin
		state_d   = state_q;
		hdr_d     = hdr_q;
		hdr_cnt_d = hdr_cnt_q;
		remain_d  = remain_q;
		kind_d    = kind_q;
		cap_d     = cap_q;
		cap_cnt_d = cap_cnt_q;
		width_d   = width_q;
		height_d  = height_q;
		finish    = 1'b0;
		push      = 1'b0;
		cap_w     = '0;
		cap_h     = '0;
		size_ok   = 1'b0;

		if (in_fire) begin
			case (state_q)
				ST_PAYLOAD: begin
					remain_d = remain_q - 32'd1;
					if (kind_q == MK_CONTENT) begin
						push = 1'b1;
					end else if (kind_q == MK_QUERY && cap_cnt_q < CAPTURE_BYTES) begin
						cap_d     = {cap_q[55:0], rx_byte};
						cap_cnt_d = cap_cnt_q + 4'd1;
					end
					finish = (remain_q == 32'd1);
				end
				ST_DROP: begin
					if (end_of_transfer) begin
						state_d = ST_HEADER;
					end
				end
				default: begin
					state_d = ST_HEADER;
					hdr_d   = hdr_full[55:0];
					if (hdr_cnt_q != 3'd7) begin
						hdr_cnt_d = hdr_cnt_q + 3'd1;
					end else begin
						hdr_cnt_d = '0;
						cap_d     = '0;
						cap_cnt_d = '0;
						if (hdr_len >= payload_limit) begin
							state_d = end_of_transfer ? ST_HEADER : ST_DROP;
						end else begin
							if (hdr_id == HDR_ID_ACCESSORY && hdr_kind == HDR_KIND_CONTENT)
								kind_d = MK_CONTENT;
							else if (hdr_id == HDR_ID_ACCESSORY && hdr_kind == HDR_KIND_QUERY)
								kind_d = MK_QUERY;
							else
								kind_d = MK_UNKNOWN;
							remain_d = hdr_len;
							if (hdr_len == 32'd0)
								finish = 1'b1;
							else
								state_d = ST_PAYLOAD;
						end
					end
				end
			endcase

			// Close the message: a query latches the peer size and asks for a reply.
			if (finish) begin
				case (kind_d)
					MK_QUERY: begin
						if (cap_cnt_d[3]) begin
							cap_w = cap_d[63:32];
							cap_h = cap_d[31:0];
						end
						size_ok = (cap_w != 32'd0) && !cap_w[31] &&
						          (cap_h != 32'd0) && !cap_h[31];
						width_d  = size_ok ? cap_w[30:0] : '0;
						height_d = size_ok ? cap_h[30:0] : '0;
						push     = 1'b1;
						state_d  = ST_HEADER;
					end
					MK_CONTENT: begin
						state_d = ST_HEADER;
					end
					default: begin
						state_d = end_of_transfer ? ST_HEADER : ST_DROP;
					end
				endcase
			end
		end
	end

	always_comb begin
		cmd.reply  = (state_q == ST_PAYLOAD && kind_q == MK_CONTENT) ? 1'b0 : 1'b1;
		cmd.data   = rx_byte;
		cmd.width  = width_d;
		cmd.height = height_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HEADER;
			hdr_q     <= '0;
			hdr_cnt_q <= '0;
			remain_q  <= '0;
			kind_q    <= MK_CONTENT;
			cap_q     <= '0;
			cap_cnt_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
		end else begin
			state_q   <= state_d;
			hdr_q     <= hdr_d;
			hdr_cnt_q <= hdr_cnt_d;
			remain_q  <= remain_d;
			kind_q    <= kind_d;
			cap_q     <= cap_d;
			cap_cnt_q <= cap_cnt_d;
			width_q   <= width_d;
			height_q  <= height_d;
		end
	end

endmodule

### sv/adf_queue.sv
// Command queue between the parser and the emitter.
module adf_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  adf_pkg::adf_cmd_t push_cmd,
	input  logic              pop,
	output adf_pkg::adf_cmd_t head,
	output logic              not_empty,
	output logic              full
);
	import adf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	adf_cmd_t        entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/adf_back.sv
// Emitter: plays queued commands out as stream beats or 20-beat replies.
module adf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  adf_pkg::adf_cmd_t   head,
	input  logic                head_valid,
	input  adf_pkg::adf_reply_t reply_words,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output logic                out_kind,
	output logic [7:0]          out_byte,
	output logic                last_of_run,
	output logic [30:0]         peer_width,
	output logic [30:0]         peer_height
);
	import adf_pkg::*;

	logic [4:0]  idx_q;
	logic        load;
	logic [31:0] word;
	logic [7:0]  reply_byte;
	logic        reply_end;

	logic        valid_q;
	logic        kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [30:0] width_q;
	logic [30:0] height_q;

	assign load      = !valid_q || !out_stall;
	assign reply_end = (idx_q == REPLY_LAST);

	always_comb begin
		case (idx_q[4:2])
			WORD_WIDTH:  word = reply_words.width;
			WORD_HEIGHT: word = reply_words.height;
			default:     word = reply_words.dpi;
		endcase
		if (idx_q[4:3] == 2'b00)
			reply_byte = REPLY_PREAMBLE[6'd63 - {idx_q[2:0], 3'b000} -: 8];
		else
			reply_byte = word[5'd31 - {idx_q[1:0], 3'b000} -: 8];
	end

	assign pop = load && head_valid && (!head.reply || reply_end);

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			kind_q   <= head.reply ? OUT_REPLY : OUT_STREAM;
			byte_q   <= head.reply ? reply_byte : head.data;
			last_q   <= !head.reply || reply_end;
			width_q  <= head.width;
			height_q <= head.height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid && head.reply) begin
				idx_q <= reply_end ? '0 : idx_q + 5'd1;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_kind    = kind_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;
	assign peer_width  = width_q;
	assign peer_height = height_q;

endmodule

### sv/accessory_display_deframer.sv
// Top level of the accessory display deframer: config registers, parser, queue, emitter.
//
// Usage:
//   Input channel: one received byte per beat (rx_byte) with end_of_transfer set
//   on the final byte of a transfer. A beat is taken when in_valid is high and
//   in_stall is low. Output channel: one result per beat, out_kind 0 for a
//   video stream byte, 1 for a reply byte to the peer; last_of_run marks the
//   final result caused by one input byte, and peer_width/peer_height carry the
//   peer size as it stands after that input byte.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 payload limit, 1/2/3 reply width/height/dpi); write only while idle.
// Timing:
//   The parser takes one byte every cycle while in_stall is low. A content
//   payload byte goes through a queue entry, then the output register. A
//   finished query emits a 20-beat reply, one beat per cycle from the emitter
//   while out_stall is low; the QUEUE_DEPTH-entry command queue absorbs
//   input during that burst, and in_stall rises only when the queue is full.
// Reset: config registers return to their default values, the parser waits for a
//   header, the queue empties and out_valid drops.
// Receiver stall: the output register holds its beat; the emitter stops,
//   the queue fills and then in_stall is raised toward the sender.
module accessory_display_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_transfer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic [30:0] peer_width,
	output logic [30:0] peer_height
);
	import adf_pkg::*;

	logic [31:0] limit_q;
	adf_reply_t  reply_q;

	logic        in_fire;
	logic        push;
	adf_cmd_t    push_cmd;
	logic        pop;
	adf_cmd_t    head;
	logic        head_valid;
	logic        q_full;

	// Configuration registers; user writes only while the block is idle, unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= RST_PAYLOAD_LIMIT;
			reply_q.width  <= RST_REPLY_WIDTH;
			reply_q.height <= RST_REPLY_HEIGHT;
			reply_q.dpi    <= RST_REPLY_DPI;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PAYLOAD_LIMIT: limit_q        <= cfg_data;
				CFG_REPLY_WIDTH:   reply_q.width  <= cfg_data;
				CFG_REPLY_HEIGHT:  reply_q.height <= cfg_data;
				CFG_REPLY_DPI:     reply_q.dpi    <= cfg_data;
				default:           limit_q        <= limit_q;
			endcase
		end
	end

	// Stall the sender only when no queue slot is left for a command.
	assign in_stall = q_full;
	assign in_fire  = in_valid && !in_stall;

	adf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.rx_byte         (rx_byte),
		.end_of_transfer (end_of_transfer),
		.payload_limit   (limit_q),
		.push            (push),
		.cmd             (push_cmd)
	);

	adf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (q_full)
	);

	adf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.reply_words (reply_q),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.peer_width  (peer_width),
		.peer_height (peer_height)
	);

endmodule

### sv/adf_checker.sv
// Port-level checks of the accessory display deframer, bound to the top level.
module adf_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        out_kind,
	input logic [7:0]  out_byte,
	input logic        last_of_run,
	input logic [30:0] peer_width,
	input logic [30:0] peer_height
);
	import adf_pkg::*;

	// A stalled beat stays and holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
		else $error("output beat changed while stalled");

	// Every stream byte is a run of its own.
	a_stream_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == OUT_STREAM |-> last_of_run)
		else $error("stream beat without last_of_run");

	// A reply runs on without gaps and with one peer size.
	a_reply_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_kind == OUT_REPLY && !last_of_run |=>
		out_valid && out_kind == OUT_REPLY &&
		$stable(peer_width) && $stable(peer_height))
		else $error("reply burst broken");

	// Peer width and height are both zero or both set.
	a_peer_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((peer_width == '0) == (peer_height == '0)))
		else $error("peer size half zero");

endmodule

bind accessory_display_deframer adf_port_checker u_adf_checker (.*);
